### hw/rtl/bucket_chain_hash_join_macros.svh
// Assertion helpers shared by the hash join RTL.
`ifndef BUCKET_CHAIN_HASH_JOIN_MACROS_SVH
`define BUCKET_CHAIN_HASH_JOIN_MACROS_SVH

// Check that an antecedent is always followed by a consequent in the next cycle.
`define BCHJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bchj: sequencing check failed");

// Check that a condition holds on every clock edge out of reset.
`define BCHJ_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("bchj: invariant check failed");

`endif

### hw/rtl/bchj_pkg.sv
`default_nettype none

package bchj_pkg;

  // Result count fields are fixed at 12 bits and wrap.
  localparam int CNT_W = 12;
  // Result tdata: match_count then chain_length.
  localparam int OUT_DW = 2 * CNT_W;
  // bucket_bits register
  localparam int CFG_W = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd12;

  // Action codes carried on in_tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_PROBE  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic clear;      // zero one bucket head during the clearing pass
    logic capture;    // latch the accepted beat and its bucket
    logic head_rd;    // read the bucket head
    logic decide;     // insert, drop, or start the chain walk
    logic walk_step;  // count one chain entry
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last bucket
    logic is_probe;   // held item is a probe
    logic head_zero;  // bucket chain is empty
    logic link_zero;  // current entry ends the chain
  } sts_t;

endpackage

`default_nettype wire

### hw/rtl/bchj_dp.sv
`default_nettype none

module bchj_dp #(
  parameter int MAX_BUCKET_BITS = 12,
  parameter int ENTRY_BITS      = 12,
  parameter int KEY_WIDTH       = 32,
  parameter int PAYLOAD_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire bchj_pkg::cmd_t                      cmd,
  output bchj_pkg::sts_t                           sts,
  input  wire logic                                in_action,
  input  wire logic [KEY_WIDTH-1:0]                in_key,
  input  wire logic [PAYLOAD_WIDTH-1:0]            in_payload,
  input  wire logic                                cfg_we,
  input  wire logic [bchj_pkg::CFG_W-1:0]          cfg_wdata,
  output logic                                     res_status,
  output logic [bchj_pkg::CNT_W-1:0]               res_match_count,
  output logic [bchj_pkg::CNT_W-1:0]               res_chain_length
);

  localparam int HEAD_DEPTH = 1 << MAX_BUCKET_BITS;
  localparam int NUM_ENTRIES = 1 << ENTRY_BITS;
  localparam int HASH_W = (KEY_WIDTH > MAX_BUCKET_BITS) ? KEY_WIDTH : MAX_BUCKET_BITS;
  localparam int ENT_W = ENTRY_BITS + KEY_WIDTH;

  // Storage
  logic [ENTRY_BITS-1:0]    head_mem [HEAD_DEPTH];
  logic [ENT_W-1:0]         entry_mem [NUM_ENTRIES];
  logic [PAYLOAD_WIDTH-1:0] payload_mem [NUM_ENTRIES];

  logic [bchj_pkg::CFG_W-1:0] bucket_bits_r;
  logic [MAX_BUCKET_BITS-1:0] clr_cnt_r;
  logic [ENTRY_BITS:0]        free_ptr_r;
  logic                       action_r;
  logic [KEY_WIDTH-1:0]       key_r;
  logic [PAYLOAD_WIDTH-1:0]   payload_r;
  logic [MAX_BUCKET_BITS-1:0] bucket_r;
  logic [MAX_BUCKET_BITS-1:0] bucket_nxt;
  logic [ENTRY_BITS-1:0]      head_rd_r;
  logic [ENT_W-1:0]           entry_rd_r;
  logic                       drop_r;
  logic [bchj_pkg::CNT_W-1:0] match_cnt_r;
  logic [bchj_pkg::CNT_W-1:0] chain_len_r;
  logic                       status_r;
  logic [bchj_pkg::CNT_W-1:0] match_out_r;
  logic [bchj_pkg::CNT_W-1:0] chain_out_r;

  logic [HASH_W-1:0]          key_ext;
  logic                       full;
  logic                       do_insert;
  logic                       walk_first;
  logic                       ent_rd;
  logic [ENTRY_BITS-1:0]      ent_rd_addr;
  logic [ENTRY_BITS-1:0]      cur_link;
  logic [KEY_WIDTH-1:0]       cur_key;
  logic                       head_we;
  logic [MAX_BUCKET_BITS-1:0] head_waddr;
  logic [ENTRY_BITS-1:0]      head_wdata;

  // Hash: low key bits, masked to the configured bucket count
  always_comb begin
    key_ext = HASH_W'(in_key);
    for (int i = 0; i < MAX_BUCKET_BITS; i++) begin
      bucket_nxt[i] = key_ext[i] & ({1'b0, bucket_bits_r} > 5'(i));
    end
  end

  assign full       = free_ptr_r[ENTRY_BITS];
  assign cur_link   = entry_rd_r[ENT_W-1:KEY_WIDTH];
  assign cur_key    = entry_rd_r[KEY_WIDTH-1:0];
  assign do_insert  = cmd.decide && (action_r == bchj_pkg::ACT_INSERT) && !full;
  assign walk_first = cmd.decide && (action_r == bchj_pkg::ACT_PROBE) && (head_rd_r != '0);
  assign ent_rd     = walk_first || (cmd.walk_step && (cur_link != '0));
  assign ent_rd_addr = walk_first ? head_rd_r : cur_link;

  // Head write port: clearing pass or chain insert
  assign head_we    = cmd.clear || do_insert;
  assign head_waddr = cmd.clear ? clr_cnt_r : bucket_r;
  assign head_wdata = cmd.clear ? '0 : free_ptr_r[ENTRY_BITS-1:0];

  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_waddr] <= head_wdata;
    end
    if (cmd.head_rd) begin
      head_rd_r <= head_mem[bucket_r];
    end
  end

  // Entry store: link above key, payload kept alongside
  always_ff @(posedge clk) begin
    if (do_insert) begin
      entry_mem[free_ptr_r[ENTRY_BITS-1:0]]   <= {head_rd_r, key_r};
      payload_mem[free_ptr_r[ENTRY_BITS-1:0]] <= payload_r;
    end
    if (ent_rd) begin
      entry_rd_r <= entry_mem[ent_rd_addr];
    end
  end

  // Control registers: config, clearing counter, free pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_bits_r <= bchj_pkg::CFG_RESET;
      clr_cnt_r     <= '0;
      free_ptr_r    <= (ENTRY_BITS+1)'(1);
    end else begin
      if (cfg_we) begin
        bucket_bits_r <= cfg_wdata;
      end
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (do_insert) begin
        free_ptr_r <= free_ptr_r + 1'b1;
      end
    end
  end

  // Hold the accepted beat
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      action_r  <= in_action;
      key_r     <= in_key;
      payload_r <= in_payload;
      bucket_r  <= bucket_nxt;
    end
  end

  // Walk counters and drop flag
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      drop_r      <= (action_r == bchj_pkg::ACT_INSERT) && full;
      match_cnt_r <= '0;
      chain_len_r <= '0;
    end else if (cmd.walk_step) begin
      chain_len_r <= chain_len_r + 1'b1;
      match_cnt_r <= match_cnt_r + bchj_pkg::CNT_W'(cur_key == key_r);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status_r    <= drop_r;
      match_out_r <= match_cnt_r;
      chain_out_r <= chain_len_r;
    end
  end

  assign res_status       = status_r;
  assign res_match_count  = match_out_r;
  assign res_chain_length = chain_out_r;

  assign sts.clr_last  = &clr_cnt_r;
  assign sts.is_probe  = (action_r == bchj_pkg::ACT_PROBE);
  assign sts.head_zero = (head_rd_r == '0);
  assign sts.link_zero = (cur_link == '0);

endmodule

`default_nettype wire

### hw/rtl/bchj_ctrl.sv
`default_nettype none

module bchj_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire bchj_pkg::sts_t sts,
  output bchj_pkg::cmd_t      cmd,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_HEAD   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_WALK   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // Sequence one item at a time
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_HEAD;
        end
      end
      ST_HEAD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = (sts.is_probe && !sts.head_zero) ? ST_WALK : ST_DONE;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.link_zero) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output beat valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/bucket_chain_hash_join.sv
`default_nettype none
`include "bucket_chain_hash_join_macros.svh"
// Channel  Dir  Payload
// in_      in   tuser: action; tdata: key, payload (zero padded to bytes)
// out_     out  tuser: status; tdata: match_count, chain_length
// cfg_     in   wdata: bucket_bits, written when cfg_we is high
//
// An insert runs from accept through the head read and the decision step to
// the result load; a probe also walks its chain, one entry read from the
// entry store per cycle. One item is worked on at a time; a finished result
// waits in the output register while the next beat is accepted.
// After reset the bucket heads are cleared, one per cycle, all
// 2^MAX_BUCKET_BITS of them; in_tready stays low until then.

module bucket_chain_hash_join #(
  parameter int MAX_BUCKET_BITS = 12,
  parameter int ENTRY_BITS      = 12,
  parameter int KEY_WIDTH       = 32,
  parameter int PAYLOAD_WIDTH   = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // [KEY_WIDTH-1:0] key, then payload, then zero padding
  input  wire logic [((KEY_WIDTH+PAYLOAD_WIDTH+7)/8)*8-1:0] in_tdata,
  // [0] action
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [11:0] match_count, [23:12] chain_length
  output logic [bchj_pkg::OUT_DW-1:0]              out_tdata,
  // [0] status
  output logic                                     out_tuser,
  input  wire logic                                cfg_we,
  input  wire logic [bchj_pkg::CFG_W-1:0]          cfg_wdata
);

  bchj_pkg::cmd_t             cmd;
  bchj_pkg::sts_t             sts;
  logic [bchj_pkg::CNT_W-1:0] res_match_count;
  logic [bchj_pkg::CNT_W-1:0] res_chain_length;

  bchj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .sts       (sts),
    .cmd       (cmd),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready)
  );

  bchj_dp #(
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
    .ENTRY_BITS      (ENTRY_BITS),
    .KEY_WIDTH       (KEY_WIDTH),
    .PAYLOAD_WIDTH   (PAYLOAD_WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_tuser),
    .in_key           (in_tdata[KEY_WIDTH-1:0]),
    .in_payload       (in_tdata[KEY_WIDTH +: PAYLOAD_WIDTH]),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .res_status       (out_tuser),
    .res_match_count  (res_match_count),
    .res_chain_length (res_chain_length)
  );

  assign out_tdata = {res_chain_length, res_match_count};

  // Every accepted beat is followed by its head read
  `BCHJ_ASSERT_NEXT(a_accept_head, clk, rst_n, in_tvalid && in_tready, cmd.head_rd)
  // Head read always leads straight into the decision step
  `BCHJ_ASSERT_NEXT(a_head_decide, clk, rst_n, cmd.head_rd, cmd.decide)
  // At most one sequencing command at a time
  `BCHJ_ASSERT_ALWAYS(a_cmd_excl, clk, rst_n,
    $onehot0({cmd.clear, cmd.capture, cmd.head_rd, cmd.decide, cmd.walk_step, cmd.load_out}))
  // Result register is never reloaded while an untaken beat waits
  `BCHJ_ASSERT_ALWAYS(a_no_overwrite, clk, rst_n,
    !(cmd.load_out && out_tvalid && !out_tready))

endmodule

`default_nettype wire

### tb/bucket_chain_hash_join_tb.sv
`timescale 1ns / 1ps

module bucket_chain_hash_join_tb;

  localparam int BUCKET_BITS_MAX = 12;
  localparam int ENTRY_COUNT     = 4096;
  localparam int HOLD_CYCLES     = 300;
  localparam int TAIL_CYCLES     = 64;
  localparam int REPORT_LIMIT    = 10;
  localparam logic [31:0] FILL_KEY = 32'hC3A5_0000;

  typedef struct packed {
    logic        status;
    logic [11:0] chain_len;
    logic [11:0] match_cnt;
  } join_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [63:0]                     in_tdata;   // [31:0] key, [63:32] payload
  logic                            in_tuser;   // [0] action
  logic                            out_tvalid;
  logic                            out_tready;
  logic [bchj_pkg::OUT_DW-1:0]     out_tdata;  // [11:0] match_count, [23:12] chain_length
  logic                            out_tuser;  // [0] status
  logic                            cfg_we;
  logic [bchj_pkg::CFG_W-1:0]      cfg_wdata;

  // Shadow copy of the hash table
  logic [11:0]                 head_tbl [ENTRY_COUNT];
  logic [31:0]                 key_tbl  [ENTRY_COUNT];
  logic [11:0]                 link_tbl [ENTRY_COUNT];
  logic [12:0]                 next_free;
  logic [bchj_pkg::CFG_W-1:0]  bucket_bits_q;

  join_result_t pending_results [$];
  join_result_t want_res;
  join_result_t got_res;
  int           error_count;

  // Sender and receiver controls
  bit           tx_gaps_on;
  bit           tx_valid_high;
  int           burst_left;
  bit           rx_stalls_on;
  bit           rx_ready_phase;
  int           rx_run_left;
  bit           hold_req;
  int           hold_left;
  logic [31:0]  key_pool [16];

  bucket_chain_hash_join u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Insert into or walk the shadow table and return the result the beat should give
  function automatic join_result_t join_table_step(input logic action, input logic [31:0] key);
    join_result_t res;
    logic [11:0]  bucket;
    logic [11:0]  hit;
    int           bits;
    int           steps;
    res  = '0;
    bits = (bucket_bits_q > BUCKET_BITS_MAX) ? BUCKET_BITS_MAX : int'(bucket_bits_q);
    bucket = 12'(key & ((32'd1 << bits) - 32'd1));
    if (action == bchj_pkg::ACT_INSERT) begin
      if (next_free >= ENTRY_COUNT) begin
        res.status = 1'b1;
      end else begin
        link_tbl[next_free[11:0]] = head_tbl[bucket];
        key_tbl[next_free[11:0]]  = key;
        head_tbl[bucket]          = next_free[11:0];
        next_free                 = next_free + 13'd1;
      end
    end else begin
      hit   = head_tbl[bucket];
      steps = 0;
      while (hit != 12'd0 && steps < ENTRY_COUNT) begin
        res.chain_len = res.chain_len + 12'd1;
        if (key_tbl[hit] == key) res.match_cnt = res.match_cnt + 12'd1;
        hit   = link_tbl[hit];
        steps = steps + 1;
      end
    end
    return res;
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < REPORT_LIMIT) $display("[%0t] ERROR: %s", $realtime, msg);
    error_count = error_count + 1;
  endtask

  // Offer one beat, idling first when gaps are on and a burst has run out
  task automatic send_item(input logic action, input logic [31:0] key,
                           input logic [31:0] payload);
    if (tx_gaps_on && burst_left == 0) begin
      in_tvalid    <= 1'b0;
      tx_valid_high = 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
      burst_left = $urandom_range(16, 1);
    end
    if (burst_left > 0) burst_left = burst_left - 1;
    in_tvalid    <= 1'b1;
    in_tuser     <= action;
    in_tdata     <= {payload, key};
    tx_valid_high = 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(join_table_step(action, key));
  endtask

  // Pause the sender until every expected result has arrived
  task automatic wait_results_drained;
    if (tx_valid_high) begin
      in_tvalid    <= 1'b0;
      tx_valid_high = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_bucket_bits(input logic [bchj_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    bucket_bits_q = value;
  endtask

  task automatic send_random_item;
    logic [31:0] key;
    int          pick;
    pick = $urandom_range(7, 0);
    if (pick == 0) key = $urandom();
    else if (pick == 1) key = $urandom_range(1, 0) ? 32'hFFFF_FFFF : 32'h0;
    else key = key_pool[$urandom_range(15, 0)];
    send_item($urandom_range(1, 0) ? bchj_pkg::ACT_PROBE : bchj_pkg::ACT_INSERT,
              key, $urandom());
  endtask

  // Empty table, extreme keys and payloads, duplicates sharing a bucket
  task automatic test_directed_extremes;
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0000, 32'h0000_0000);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bchj_pkg::ACT_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_item(bchj_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(bchj_pkg::ACT_INSERT, 32'h0000_1000, 32'hA5A5_5A5A);
    send_item(bchj_pkg::ACT_INSERT, 32'h0000_0000, 32'h5A5A_A5A5);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0000, 32'hFFFF_FFFF);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_1000, 32'h0000_0000);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'h0000_0000);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_2000, 32'h0000_0000);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0FFF, 32'h0000_0000);
  endtask

  // Zero bits, saturating values and changes of mask over existing chains
  task automatic test_bucket_bits_edges;
    wait_results_drained();
    write_bucket_bits(4'd0);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'h0);
    send_item(bchj_pkg::ACT_INSERT, 32'h0000_0005, 32'h1234_5678);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0005, 32'h0);
    wait_results_drained();
    write_bucket_bits(4'd15);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0000, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0005, 32'h0);
    send_item(bchj_pkg::ACT_INSERT, 32'h8000_0FFF, 32'h8765_4321);
    wait_results_drained();
    write_bucket_bits(4'd1);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'h8000_0FFF, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0002, 32'h0);
    wait_results_drained();
    write_bucket_bits(4'd13);
    send_item(bchj_pkg::ACT_PROBE,  32'h8000_0FFF, 32'h0);
  endtask

  // Random mixes of inserts and probes under several masks
  task automatic test_random_phases;
    logic [bchj_pkg::CFG_W-1:0] phase_bits [7];
    phase_bits = '{4'd1, 4'd12, 4'd4, 4'd0, 4'd9, 4'd13, 4'd0};
    phase_bits[6] = $urandom_range(15, 0);
    for (int i = 0; i < 16; i++) key_pool[i] = $urandom() & 32'hFFFF_F00F;
    for (int ph = 0; ph < 7; ph++) begin
      wait_results_drained();
      write_bucket_bits(phase_bits[ph]);
      // one phase runs flat out on both sides
      tx_gaps_on   = (ph != 2);
      rx_stalls_on = (ph != 2);
      for (int n = 0; n < 70; n++) send_random_item();
    end
  endtask

  // Long receiver hold-off against a sender that never idles, then a run with sender gaps
  task automatic test_backpressure;
    wait_results_drained();
    write_bucket_bits(4'd6);
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b1;
    hold_req     = 1'b1;
    for (int n = 0; n < 40; n++) send_random_item();
    wait_results_drained();
    tx_gaps_on = 1'b1;
    for (int n = 0; n < 20; n++) send_random_item();
  endtask

  // Fill the entry store, check dropped inserts and walks over the whole store
  task automatic test_store_full;
    wait_results_drained();
    write_bucket_bits(4'd12);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    while (next_free < ENTRY_COUNT)
      send_item(bchj_pkg::ACT_INSERT, $urandom_range(1, 0) ? FILL_KEY : $urandom(),
                $urandom());
    send_item(bchj_pkg::ACT_INSERT, FILL_KEY, 32'hFFFF_FFFF);
    send_item(bchj_pkg::ACT_INSERT, 32'hFFFF_FFFF, 32'h0);
    send_item(bchj_pkg::ACT_INSERT, 32'h0, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  FILL_KEY, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'h0);
    wait_results_drained();
    write_bucket_bits(4'd0);
    send_item(bchj_pkg::ACT_PROBE,  FILL_KEY, 32'h0);
    send_item(bchj_pkg::ACT_INSERT, FILL_KEY, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'hFFFF_FFFF, 32'h0);
    wait_results_drained();
    write_bucket_bits(4'd3);
    send_item(bchj_pkg::ACT_PROBE,  FILL_KEY, 32'h0);
    send_item(bchj_pkg::ACT_PROBE,  32'h0000_0007, 32'h0);
  endtask

  // Receiver: random ready and stall runs, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left   = hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_run_left == 0) begin
        rx_ready_phase = !rx_ready_phase;
        rx_run_left    = rx_ready_phase ? $urandom_range(12, 1) : $urandom_range(6, 1);
      end
      rx_run_left = rx_run_left - 1;
      out_tready <= rx_ready_phase || !rx_stalls_on;
    end
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_res.status    = out_tuser;
      got_res.match_cnt = out_tdata[11:0];
      got_res.chain_len = out_tdata[23:12];
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result status=%0d match=%0d chain=%0d",
                             got_res.status, got_res.match_cnt, got_res.chain_len));
      end else begin
        want_res = pending_results.pop_front();
        if (got_res.status !== want_res.status ||
            got_res.match_cnt !== want_res.match_cnt ||
            got_res.chain_len !== want_res.chain_len)
          flag_error($sformatf(
            "expected status=%0d match=%0d chain=%0d, got status=%0d match=%0d chain=%0d",
            want_res.status, want_res.match_cnt, want_res.chain_len,
            got_res.status, got_res.match_cnt, got_res.chain_len));
      end
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = 1'b0;
    out_tready     = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    error_count    = 0;
    tx_gaps_on     = 1'b1;
    tx_valid_high  = 1'b0;
    burst_left     = 0;
    rx_stalls_on   = 1'b1;
    rx_ready_phase = 1'b0;
    rx_run_left    = 0;
    hold_req       = 1'b0;
    hold_left      = 0;
    for (int i = 0; i < ENTRY_COUNT; i++) begin
      head_tbl[i] = '0;
      key_tbl[i]  = '0;
      link_tbl[i] = '0;
    end
    next_free     = 13'd1;
    bucket_bits_q = bchj_pkg::CFG_RESET;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // hold off until the bucket clearing pass has finished
    do @(posedge clk); while (!in_tready);

    test_directed_extremes();
    test_bucket_bits_edges();
    test_random_phases();
    test_backpressure();
    test_store_full();

    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
